>>> rtl/core/s16p_pkg.sv
// ----------------------------------------------------------------------------
// s16p_pkg
// types and scheme table shared by the simple16 word packer
// ----------------------------------------------------------------------------
package s16p_pkg;

  localparam int unsigned WinDepth   = 30;
  localparam int unsigned CntW       = 5;
  localparam int unsigned NumSchemes = 15;
  localparam logic [3:0]  SelRaw     = 4'd15;

  typedef struct packed {
    logic [63:0] value;
    logic        stream_end;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] word;
    logic        run_last;
    logic        stream_last;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_DECIDE,
    ST_RAW,
    ST_OUT
  } state_t;

  // fit flags carried by each cell: bit k set when the value fits width of scheme k
  typedef logic [NumSchemes-1:0] fit_t;

  function automatic logic [3:0] scheme_sel(input logic [3:0] s);
    logic [3:0] r;
    unique case (s)
      4'd0:    r = 4'd13;
      4'd1:    r = 4'd0;
      4'd2:    r = 4'd1;
      4'd3:    r = 4'd2;
      4'd4:    r = 4'd14;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd4;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd6;
      4'd9:    r = 4'd7;
      4'd10:   r = 4'd8;
      4'd11:   r = 4'd9;
      4'd12:   r = 4'd10;
      4'd13:   r = 4'd11;
      default: r = 4'd12;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] scheme_count(input logic [3:0] s);
    logic [4:0] r;
    unique case (s)
      4'd0:    r = 5'd30;
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd20;
      4'd3:    r = 5'd15;
      4'd4:    r = 5'd14;
      4'd5:    r = 5'd12;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd8;
      4'd8:    r = 5'd7;
      4'd9:    r = 5'd6;
      4'd10:   r = 5'd5;
      4'd11:   r = 5'd4;
      4'd12:   r = 5'd3;
      4'd13:   r = 5'd2;
      default: r = 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] scheme_width(input logic [3:0] s);
    logic [5:0] r;
    unique case (s)
      4'd0, 4'd1: r = 6'd2;
      4'd2:       r = 6'd3;
      4'd3, 4'd4: r = 6'd4;
      4'd5:       r = 6'd5;
      4'd6:       r = 6'd6;
      4'd7:       r = 6'd7;
      4'd8:       r = 6'd8;
      4'd9:       r = 6'd10;
      4'd10:      r = 6'd12;
      4'd11:      r = 6'd15;
      4'd12:      r = 6'd20;
      4'd13:      r = 6'd30;
      default:    r = 6'd60;
    endcase
    return r;
  endfunction

  // fit flags of one value against every scheme width
  function automatic fit_t value_fits(input logic [63:0] v);
    fit_t f;
    for (int k = 0; k < NumSchemes; k++) begin
      f[k] = ((v >> scheme_width(4'(k))) == 64'd0);
    end
    return f;
  endfunction

endpackage

>>> rtl/core/s16p_cell.sv
// ----------------------------------------------------------------------------
// s16p_cell
// one window slot: holds a value and its fit flags, shifts toward the head
// ----------------------------------------------------------------------------
module s16p_cell (
  input  logic                clk,
  input  logic                load,
  input  logic                shift,
  input  logic [63:0]         load_value,
  input  logic [63:0]         next_value,
  input  s16p_pkg::fit_t      next_fit,
  output logic [63:0]         value,
  output s16p_pkg::fit_t      fit
);

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= next_value;
      fit   <= next_fit;
    end else if (load) begin
      value <= load_value;
      fit   <= s16p_pkg::value_fits(load_value);
    end
  end

endmodule

>>> rtl/core/s16p_window.sv
// ----------------------------------------------------------------------------
// s16p_window
// chain of window cells; the head cell value feeds the packing accumulator
// ----------------------------------------------------------------------------
module s16p_window (
  input  logic                       clk,
  input  logic                       load,
  input  logic [s16p_pkg::CntW-1:0]  load_idx,
  input  logic [63:0]                load_value,
  input  logic                       shift,
  output logic [63:0]                head_value,
  output s16p_pkg::fit_t             fit_all [s16p_pkg::WinDepth]
);

  logic [63:0]    vals [s16p_pkg::WinDepth];
  s16p_pkg::fit_t fits [s16p_pkg::WinDepth];

  for (genvar i = 0; i < s16p_pkg::WinDepth; i++) begin : g_cell
    logic [63:0]    nv;
    s16p_pkg::fit_t nf;
    if (i == s16p_pkg::WinDepth - 1) begin : g_tail
      assign nv = 64'd0;
      assign nf = '0;
    end else begin : g_mid
      assign nv = vals[i+1];
      assign nf = fits[i+1];
    end
    s16p_cell u_cell (
      .clk        (clk),
      .load       (load && (load_idx == s16p_pkg::CntW'(i))),
      .shift      (shift),
      .load_value (load_value),
      .next_value (nv),
      .next_fit   (nf),
      .value      (vals[i]),
      .fit        (fits[i])
    );
    assign fit_all[i] = fits[i];
  end

  assign head_value = vals[0];

endmodule

>>> rtl/core/simple16_word_packer.sv
// ----------------------------------------------------------------------------
// simple16_word_packer
// packs a stream of unsigned 64-bit values into simple16-style 64-bit words
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_data) takes one value per beat, the
//   final value of a stream marked by stream_end. out channel (out_valid/
//   out_stall/out_data) gives packed words: selector in bits 63..60, values
//   packed from bit 0; a value no scheme fits goes out as a marker word with
//   selector 15 followed by the raw value.
//   values collect in a 30-slot window built as a chain of cells. when the
//   window fills, or a stream ends, a scheme is chosen from fit flags kept
//   per cell, then the chosen values shift out of the head cell one per
//   cycle into a packing register. a packed word is offered once its
//   values have shifted in; a marker word is offered after the decide
//   step with no shifts. one item is worked at a time; in_stall is high
//   while words are pending. reset clears the fill count and the state
//   machine; window data is not cleared. a stalled output beat holds
//   until taken.
// ----------------------------------------------------------------------------
module simple16_word_packer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  s16p_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output s16p_pkg::out_beat_t   out_data
);

  s16p_pkg::state_t state, state_next;

  logic [s16p_pkg::CntW-1:0] count;      // values held in the window
  logic                      flushing;   // current item ended the stream
  logic [3:0]                scheme;     // chosen scheme index
  logic [s16p_pkg::CntW-1:0] remain;     // values still to shift into the word
  logic [5:0]                bitpos;     // next packing position
  logic [63:0]               acc;        // word under construction
  logic                      raw_pend;   // raw value still to send after marker

  logic                      in_take;
  logic                      out_take;
  logic                      shift;
  logic [63:0]               head_value;
  s16p_pkg::fit_t            fit_all [s16p_pkg::WinDepth];

  // scheme choice over the cell flags
  logic [3:0]                pick;
  logic                      pick_ok;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  s16p_window u_window (
    .clk        (clk),
    .load       (in_take),
    .load_idx   (count),
    .load_value (in_data.value),
    .shift      (shift),
    .head_value (head_value),
    .fit_all    (fit_all)
  );

  always_comb begin
    logic ok;
    pick    = 4'd0;
    pick_ok = 1'b0;
    for (int s = s16p_pkg::NumSchemes - 1; s >= 0; s--) begin
      ok = (count >= s16p_pkg::scheme_count(4'(s)));
      for (int i = 0; i < s16p_pkg::WinDepth; i++) begin
        if (i < s16p_pkg::scheme_count(4'(s)) && !fit_all[i][s]) ok = 1'b0;
      end
      if (ok) begin
        pick    = 4'(s);
        pick_ok = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      s16p_pkg::ST_FILL: begin
        if (in_take && (in_data.stream_end ||
            (count == s16p_pkg::CntW'(s16p_pkg::WinDepth - 1)))) begin
          state_next = s16p_pkg::ST_DECIDE;
        end
      end
      s16p_pkg::ST_DECIDE: begin
        state_next = pick_ok ? s16p_pkg::ST_RAW : s16p_pkg::ST_OUT;
      end
      s16p_pkg::ST_RAW: begin
        // shifting packed values; remain reaches one on the last shift
        if (remain == s16p_pkg::CntW'(1)) state_next = s16p_pkg::ST_OUT;
      end
      s16p_pkg::ST_OUT: begin
        if (out_take && !raw_pend) begin
          if (flushing && count != '0) state_next = s16p_pkg::ST_DECIDE;
          else                         state_next = s16p_pkg::ST_FILL;
        end
      end
      default: state_next = s16p_pkg::ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != s16p_pkg::ST_FILL);
    out_valid = (state == s16p_pkg::ST_OUT);
    shift     = (state == s16p_pkg::ST_RAW) ||
                (state == s16p_pkg::ST_OUT && out_take && raw_pend);
    out_data.word        = acc;
    out_data.run_last    = !raw_pend && !(flushing && count != '0);
    out_data.stream_last = !raw_pend && flushing && count == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= s16p_pkg::ST_FILL;
      count    <= '0;
      flushing <= 1'b0;
      raw_pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        s16p_pkg::ST_FILL: begin
          if (in_take) begin
            count    <= count + 1'b1;
            flushing <= in_data.stream_end;
          end
        end
        s16p_pkg::ST_DECIDE: begin
          raw_pend <= !pick_ok;
        end
        s16p_pkg::ST_RAW: begin
          count <= count - 1'b1;
        end
        s16p_pkg::ST_OUT: begin
          if (out_take && raw_pend) begin
            raw_pend <= 1'b0;
            count    <= count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // packing datapath
  always_ff @(posedge clk) begin
    unique case (state)
      s16p_pkg::ST_DECIDE: begin
        scheme <= pick;
        remain <= s16p_pkg::scheme_count(pick);
        bitpos <= '0;
        acc    <= pick_ok ? {s16p_pkg::scheme_sel(pick), 60'd0}
                          : {s16p_pkg::SelRaw, 60'd0};
      end
      s16p_pkg::ST_RAW: begin
        acc    <= acc | ((head_value &
                  ((64'd1 << s16p_pkg::scheme_width(scheme)) - 64'd1)) << bitpos);
        bitpos <= bitpos + s16p_pkg::scheme_width(scheme);
        remain <= remain - 1'b1;
      end
      s16p_pkg::ST_OUT: begin
        if (out_take && raw_pend) acc <= head_value;
      end
      default: ;
    endcase
  end

  // window never overflows
  assert property (@(posedge clk) disable iff (rst)
    count <= s16p_pkg::CntW'(s16p_pkg::WinDepth))
    else $error("window count overflow");

  // no input is taken while words are pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_take)
    else $error("input taken during output");

  // a stream-final word leaves the window empty
  assert property (@(posedge clk) disable iff (rst)
    (out_take && out_data.stream_last) |=> (count == '0))
    else $error("window not empty after stream end");

endmodule

>>> tb/tb_simple16_word_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple16_word_packer
// checks the simple16 word packer against a behavioral packer in the bench
// ----------------------------------------------------------------------------
// a directed table (extremes, raw pairs, flushes) and one stream per scheme (bar
// the 28- and 20-value ones) run first, then random streams mostly of narrow values
// with some wide ones. every output beat is compared with the oldest predicted word.
// both sides idle at random; once the output holds off for a long stretch so the
// window backs up, and once the sender waits until every predicted word has come out.
// ----------------------------------------------------------------------------
module tb_simple16_word_packer;

  localparam int NumDirected = 22;
  localparam int NumItems    = 160;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  s16p_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  s16p_pkg::out_beat_t out_data;

  simple16_word_packer i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // packing schemes in the order they are tried
  localparam int SchemeCnt = 15;
  localparam logic [3:0] PackSel [SchemeCnt] =
    '{4'd13, 4'd0, 4'd1, 4'd2, 4'd14, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
      4'd10, 4'd11, 4'd12};
  localparam int PackCount [SchemeCnt] =
    '{30, 28, 20, 15, 14, 12, 10, 8, 7, 6, 5, 4, 3, 2, 1};
  localparam int PackWidth [SchemeCnt] =
    '{2, 2, 3, 4, 4, 5, 6, 7, 8, 10, 12, 15, 20, 30, 60};

  // bench copy of the lookahead window
  logic [63:0]         pend_vals[$];
  s16p_pkg::out_beat_t words_due[$];
  bit                  failed;
  int                  n_sent;
  bit                  hold_out;
  bit                  hold_done;

  // directed table; typed words only where they are obvious
  typedef struct {
    logic [63:0] value;
    logic        stream_end;
    bit          typed;
    logic [63:0] word0;
  } dir_row_t;
  dir_row_t dir_rows [NumDirected];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // pack one word (or raw pair) from the window head
  task automatic pack_head(inout s16p_pkg::out_beat_t outs[$]);
    logic [63:0]         mask;
    logic [63:0]         w;
    bit                  ok;
    s16p_pkg::out_beat_t b;
    b = '0;
    for (int s = 0; s < SchemeCnt; s++) begin
      if (pend_vals.size() < PackCount[s]) continue;
      mask = (64'd1 << PackWidth[s]) - 64'd1;
      ok = 1;
      for (int i = 0; i < PackCount[s]; i++)
        if (pend_vals[i] > mask) ok = 0;
      if (ok) begin
        w = 64'(PackSel[s]) << 60;
        for (int i = 0; i < PackCount[s]; i++)
          w |= (pend_vals[i] & mask) << (i * PackWidth[s]);
        b.word = w;
        outs = {outs, b};
        for (int i = 0; i < PackCount[s]; i++) void'(pend_vals.pop_front());
        return;
      end
    end
    b.word = 64'(s16p_pkg::SelRaw) << 60;
    outs = {outs, b};
    b.word = pend_vals.pop_front();
    outs = {outs, b};
  endtask

  // words caused by one accepted value
  task automatic predict_words(input s16p_pkg::in_beat_t it);
    s16p_pkg::out_beat_t outs[$];
    pend_vals = {pend_vals, it.value};
    if (it.stream_end) begin
      while (pend_vals.size() > 0) pack_head(outs);
    end else if (pend_vals.size() == 30) begin
      pack_head(outs);
    end
    if (outs.size() > 0) begin
      outs[outs.size()-1].run_last = 1'b1;
      if (it.stream_end) outs[outs.size()-1].stream_last = 1'b1;
    end
    foreach (outs[i]) words_due = {words_due, outs[i]};
  endtask

  // compare each taken output beat with the oldest predicted word
  always @(posedge clk) begin
    s16p_pkg::out_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_data);
        failed = 1;
      end else begin
        e = words_due.pop_front();
        if (out_data.word !== e.word) begin
          $display("%0t: word expected %h actual %h", $time, e.word, out_data.word);
          failed = 1;
        end
        if (out_data.run_last !== e.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, e.run_last,
                   out_data.run_last);
          failed = 1;
        end
        if (out_data.stream_last !== e.stream_last) begin
          $display("%0t: stream_last expected %b actual %b", $time, e.stream_last,
                   out_data.stream_last);
          failed = 1;
        end
      end
    end
  end

  // receiver stall: mostly short gaps, a few long, one long hold-off
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_out && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done = 1;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 20) == 0) begin
        // run with no stall at all
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // offer one value and wait for its beat to be taken; valid stays high after
  task automatic send_value(input s16p_pkg::in_beat_t it);
    int gap;
    if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_words(it);
    n_sent++;
  endtask

  function automatic logic [63:0] rand_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 64'($urandom_range(0, 3));
    if (pick < 15) return 64'($urandom_range(0, 255));
    if (pick < 17) return 64'({$urandom, $urandom} >> $urandom_range(0, 63));
    if (pick < 18) return {$urandom, $urandom};
    return (64'd1 << $urandom_range(0, 63)) - 64'd1 + 64'($urandom_range(0, 1));
  endfunction

  initial begin
    s16p_pkg::in_beat_t it;
    int limit;
    int len;
    failed    = 0;
    n_sent    = 0;
    hold_out  = 0;
    hold_done = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;

    dir_rows[0]  = '{64'd0, 1'b1, 1, {4'd12, 60'd0}};
    dir_rows[1]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1, {4'd15, 60'd0}};
    dir_rows[2]  = '{64'h0FFF_FFFF_FFFF_FFFF, 1'b1, 1, 64'hCFFF_FFFF_FFFF_FFFF};
    dir_rows[3]  = '{64'h1000_0000_0000_0000, 1'b1, 1, {4'd15, 60'd0}};
    dir_rows[4]  = '{64'h3FFF_FFFF, 1'b0, 0, 64'd0};
    dir_rows[5]  = '{64'd1, 1'b1, 0, 64'd0};
    dir_rows[6]  = '{64'hFFFFF, 1'b0, 0, 64'd0};
    dir_rows[7]  = '{64'h8000, 1'b0, 0, 64'd0};
    dir_rows[8]  = '{64'h7FFF, 1'b1, 0, 64'd0};
    dir_rows[9]  = '{64'hFFF, 1'b0, 0, 64'd0};
    dir_rows[10] = '{64'h3FF, 1'b0, 0, 64'd0};
    dir_rows[11] = '{64'hFF, 1'b0, 0, 64'd0};
    dir_rows[12] = '{64'h7F, 1'b0, 0, 64'd0};
    dir_rows[13] = '{64'h3F, 1'b0, 0, 64'd0};
    dir_rows[14] = '{64'h1F, 1'b0, 0, 64'd0};
    dir_rows[15] = '{64'hF, 1'b0, 0, 64'd0};
    dir_rows[16] = '{64'h7, 1'b1, 0, 64'd0};
    dir_rows[17] = '{64'h5555_5555_5555_5555, 1'b0, 0, 64'd0};
    dir_rows[18] = '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 0, 64'd0};
    dir_rows[19] = '{64'h0, 1'b0, 0, 64'd0};
    dir_rows[20] = '{64'h3, 1'b0, 0, 64'd0};
    dir_rows[21] = '{64'h2, 1'b1, 0, 64'd0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed rows start a fresh window, so the first word is known
    foreach (dir_rows[r]) begin
      it.value      = dir_rows[r].value;
      it.stream_end = dir_rows[r].stream_end;
      send_value(it);
      if (dir_rows[r].typed && words_due[0].word !== dir_rows[r].word0) begin
        $display("%0t: typed row %0d expected %h predicted %h", $time, r,
                 dir_rows[r].word0, words_due[0].word);
        failed = 1;
      end
    end

    // one stream per scheme of exactly count values at its width; of the
    // long narrow windows only the first gets its own stream
    for (int s = 0; s < SchemeCnt; s++) begin
      if (s > 0 && PackCount[s] > 15) continue;
      for (int i = 0; i < PackCount[s]; i++) begin
        it.value = (64'd1 << PackWidth[s]) - 64'd1 - 64'($urandom_range(0, 1));
        it.stream_end = (i == PackCount[s] - 1);
        send_value(it);
      end
    end

    // sender pauses until every predicted word has come out
    in_valid <= 1'b0;
    while (words_due.size() > 0) @(posedge clk);

    // random streams; the long output hold-off lands near the end
    while (n_sent < NumItems) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : $urandom_range(8, 30);
      if (len > NumItems - n_sent) len = NumItems - n_sent;
      for (int i = 0; i < len; i++) begin
        if (n_sent > NumItems - 15) hold_out = 1;
        it.value      = rand_value();
        it.stream_end = (i == len - 1);
        send_value(it);
      end
    end
    in_valid <= 1'b0;

    limit = 0;
    while ((words_due.size() > 0 || !hold_done) && limit < 200000) begin
      @(posedge clk);
      limit++;
    end
    repeat (50) @(posedge clk);
    if (words_due.size() > 0) begin
      $display("%0t: %0d predicted words never came out", $time, words_due.size());
      failed = 1;
    end
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/s16p_pkg.sv
rtl/core/s16p_cell.sv
rtl/core/s16p_window.sv
rtl/core/simple16_word_packer.sv
tb/tb_simple16_word_packer.sv
